// File: rtl/core/ecd_pkg.sv
// Package: microcode word, datapath op codes, constants and tables for the epoch-to-date converter.
`default_nettype none

package ecd_pkg;

    // Step counter width and program length
    localparam int STEP_W      = 4;
    localparam int UCODE_DEPTH = 9;

    // Field widths
    localparam int SECS_W  = 32;
    localparam int DAYS_W  = 16;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int YLEN_W  = 9;

    // Calendar constants
    localparam logic [SECS_W-1:0]  SECS_PER_DAY  = 32'd86400;
    localparam logic [SECS_W-1:0]  SECS_PER_HOUR = 32'd3600;
    localparam logic [SECS_W-1:0]  SECS_PER_MIN  = 32'd60;
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
    // Only century year in 1970..2106 that is not a leap year
    localparam logic [YEAR_W-1:0]  SKIP_CENTURY  = 12'd2100;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [YLEN_W-1:0]  DAYS_LEAP     = 9'd366;
    localparam logic [YLEN_W-1:0]  DAYS_COMMON   = 9'd365;

    // Reciprocal division: q = (t * RECIP) >> SH with t the dividend shifted
    // right by PRE; exact over every dividend that can reach it.
    // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2.
    localparam int DAY_PRE     = 7;
    localparam int DAY_SH      = 35;
    localparam int DAY_PROD_W  = 51;   // 25-bit operand times 26-bit reciprocal
    localparam logic [DAY_PROD_W-1:0]  DAY_RECIP  = 51'd50903317;
    localparam int HOUR_PRE    = 4;
    localparam int HOUR_IN_W   = 17;   // remainder of a day is below 86400
    localparam int HOUR_SH     = 21;
    localparam int HOUR_PROD_W = 27;   // 13-bit operand times 14-bit reciprocal
    localparam logic [HOUR_PROD_W-1:0] HOUR_RECIP = 27'd9321;
    localparam int MIN_PRE     = 2;
    localparam int MIN_IN_W    = 12;   // remainder of an hour is below 3600
    localparam int MIN_SH      = 14;
    localparam int MIN_PROD_W  = 21;   // 10-bit operand times 11-bit reciprocal
    localparam logic [MIN_PROD_W-1:0]  MIN_RECIP  = 21'd1093;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_DAY_Q  = 4'd0,  // seconds / 86400 -> day count
        OP_DAY_R  = 4'd1,  // seconds left in the day
        OP_HOUR_Q = 4'd2,  // remainder / 3600 -> hour
        OP_HOUR_R = 4'd3,  // seconds left in the hour
        OP_MIN_Q  = 4'd4,  // remainder / 60 -> minute
        OP_MIN_R  = 4'd5,  // remainder -> second, loop counters to epoch
        OP_YEAR   = 4'd6,  // take one year off the day count
        OP_MONTH  = 4'd7,  // take one month off the day count
        OP_DONE   = 4'd8   // raise the result strobe
    } ucode_op_t;

    // One control word
    typedef struct packed {
        ucode_op_t         op;
        logic              jump;    // jump to target while the datapath condition holds
        logic [STEP_W-1:0] target;
    } ucode_word_t;

    // Loop entry points
    localparam logic [STEP_W-1:0] STEP_YEAR  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MONTH = 4'd7;

    // Program ROM
    function automatic ucode_word_t ucode_fetch(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        begin
            case (step)
                // split seconds into days, hours, minutes and seconds
                4'd0:  w = '{OP_DAY_Q,  1'b0, 4'd0};
                4'd1:  w = '{OP_DAY_R,  1'b0, 4'd0};
                4'd2:  w = '{OP_HOUR_Q, 1'b0, 4'd0};
                4'd3:  w = '{OP_HOUR_R, 1'b0, 4'd0};
                4'd4:  w = '{OP_MIN_Q,  1'b0, 4'd0};
                4'd5:  w = '{OP_MIN_R,  1'b0, 4'd0};
                // year and month loops
                4'd6:  w = '{OP_YEAR,   1'b1, STEP_YEAR};
                4'd7:  w = '{OP_MONTH,  1'b1, STEP_MONTH};
                4'd8:  w = '{OP_DONE,   1'b0, 4'd0};
                default: w = '{OP_DONE, 1'b0, 4'd0};
            endcase
            return w;
        end
    endfunction

    // Leap rule over 1970..2106: 2000 is leap, 2100 is the only skipped century
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        begin
            return (y[1:0] == 2'b00) && (y != SKIP_CENTURY);
        end
    endfunction

    // Days in a month
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/epoch_seconds_to_calendar_date.sv
// Top level: Unix seconds to UTC calendar date and time of day.
//
// Pulse start with epoch_seconds while busy is low; the value is taken at that
// edge and busy rises. A microcoded sequencer then splits off days, hours and
// minutes by reciprocal multiplication, one quotient or remainder per cycle,
// takes one year off the day count per cycle from 1970, then one month per
// cycle from January. The result sits on the cal_* ports from the single cycle
// in which done is high until the next conversion begins to overwrite it; the
// receiver cannot stall the block, so it must capture on done. A new start may
// come in that same cycle.
`default_nettype none

module epoch_seconds_to_calendar_date (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ecd_pkg::SECS_W-1:0]        epoch_seconds,
    output logic                                   busy,
    output logic                                   done,
    output logic [ecd_pkg::YEAR_W-1:0]             cal_year,
    output logic [ecd_pkg::MONTH_W-1:0]            cal_month,
    output logic [ecd_pkg::DAY_W-1:0]              cal_day,
    output logic [ecd_pkg::HOUR_W-1:0]             cal_hour,
    output logic [ecd_pkg::MIN_W-1:0]              cal_minute,
    output logic [ecd_pkg::SEC_W-1:0]              cal_second
);

    logic                  accept;
    logic                  cond;
    ecd_pkg::ucode_word_t  cw;

    // Input transfer
    assign accept = start && !busy;

    ecd_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cond   (cond),
        .cw     (cw),
        .busy   (busy),
        .done   (done)
    );

    ecd_datapath u_dp (
        .clk           (clk),
        .accept        (accept),
        .run           (busy),
        .cw            (cw),
        .epoch_seconds (epoch_seconds),
        .cond          (cond),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second)
    );

endmodule

`default_nettype wire

// File: rtl/core/ecd_sequencer.sv
// Microcode sequencer: step counter, program fetch, conditional jumps and result strobe.
`default_nettype none

module ecd_sequencer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       cond,
    output ecd_pkg::ucode_word_t            cw,
    output logic                            busy,
    output logic                            done
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ecd_pkg::STEP_W-1:0]    step_reg, step_next;

    // Fetch the current control word
    assign cw = ecd_pkg::ucode_fetch(step_reg);

    // Next step: restart on a transfer, jump while the loop condition holds
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (cw.op == ecd_pkg::OP_DONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (cw.jump && cond)
            begin
                step_next = cw.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/ecd_datapath.sv
// Datapath: reciprocal dividers, day count, year and month reduction, result registers.
`default_nettype none

module ecd_datapath (
    input  wire logic                              clk,
    input  wire logic                              accept,
    input  wire logic                              run,
    input  wire ecd_pkg::ucode_word_t              cw,
    input  wire logic [ecd_pkg::SECS_W-1:0]        epoch_seconds,
    output logic                                   cond,
    output logic [ecd_pkg::YEAR_W-1:0]             cal_year,
    output logic [ecd_pkg::MONTH_W-1:0]            cal_month,
    output logic [ecd_pkg::DAY_W-1:0]              cal_day,
    output logic [ecd_pkg::HOUR_W-1:0]             cal_hour,
    output logic [ecd_pkg::MIN_W-1:0]              cal_minute,
    output logic [ecd_pkg::SEC_W-1:0]              cal_second
);

    logic [ecd_pkg::SECS_W-1:0]  acc_reg, acc_next;
    logic [ecd_pkg::DAYS_W-1:0]  days_reg, days_next;
    logic [ecd_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [ecd_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [ecd_pkg::HOUR_W-1:0]  hour_reg, hour_next;
    logic [ecd_pkg::MIN_W-1:0]   minute_reg, minute_next;
    logic [ecd_pkg::SEC_W-1:0]   second_reg, second_next;

    logic [ecd_pkg::DAY_PROD_W-1:0]  day_prod;
    logic [ecd_pkg::HOUR_PROD_W-1:0] hour_prod;
    logic [ecd_pkg::MIN_PROD_W-1:0]  min_prod;
    logic [ecd_pkg::SECS_W-1:0]      day_secs;
    logic [ecd_pkg::SECS_W-1:0]      hour_secs;
    logic [ecd_pkg::SECS_W-1:0]      min_secs;
    logic [ecd_pkg::SECS_W-1:0]      sec_left;
    logic                        leap;
    logic [ecd_pkg::YLEN_W-1:0]  ylen;
    logic [ecd_pkg::DAY_W-1:0]   mlen;
    logic                        year_ge;
    logic                        month_ge;

    // Quotients by reciprocal multiplication (effective 25x26, 13x14, 10x11)
    assign day_prod  = {{(ecd_pkg::DAY_PROD_W-ecd_pkg::SECS_W+ecd_pkg::DAY_PRE){1'b0}},
                        acc_reg[ecd_pkg::SECS_W-1:ecd_pkg::DAY_PRE]} * ecd_pkg::DAY_RECIP;
    assign hour_prod = {{(ecd_pkg::HOUR_PROD_W-ecd_pkg::HOUR_IN_W+ecd_pkg::HOUR_PRE){1'b0}},
                        acc_reg[ecd_pkg::HOUR_IN_W-1:ecd_pkg::HOUR_PRE]} * ecd_pkg::HOUR_RECIP;
    assign min_prod  = {{(ecd_pkg::MIN_PROD_W-ecd_pkg::MIN_IN_W+ecd_pkg::MIN_PRE){1'b0}},
                        acc_reg[ecd_pkg::MIN_IN_W-1:ecd_pkg::MIN_PRE]} * ecd_pkg::MIN_RECIP;

    // Whole units back in seconds; never above the dividend, so 32 bits hold them
    assign day_secs  = {{(ecd_pkg::SECS_W-ecd_pkg::DAYS_W){1'b0}}, days_reg}
                     * ecd_pkg::SECS_PER_DAY;
    assign hour_secs = {{(ecd_pkg::SECS_W-ecd_pkg::HOUR_W){1'b0}}, hour_reg}
                     * ecd_pkg::SECS_PER_HOUR;
    assign min_secs  = {{(ecd_pkg::SECS_W-ecd_pkg::MIN_W){1'b0}}, minute_reg}
                     * ecd_pkg::SECS_PER_MIN;
    assign sec_left  = acc_reg - min_secs;

    // Year and month lengths for the current year
    assign leap     = ecd_pkg::is_leap(year_reg);
    assign ylen     = leap ? ecd_pkg::DAYS_LEAP : ecd_pkg::DAYS_COMMON;
    assign mlen     = ecd_pkg::month_length(month_reg, leap);
    assign year_ge  = days_reg >= {{(ecd_pkg::DAYS_W-ecd_pkg::YLEN_W){1'b0}}, ylen};
    assign month_ge = (month_reg < ecd_pkg::MONTH_DEC)
                   && (days_reg >= {{(ecd_pkg::DAYS_W-ecd_pkg::DAY_W){1'b0}}, mlen});

    // Loop condition seen by the sequencer
    always_comb
    begin
        case (cw.op)
            ecd_pkg::OP_YEAR:  cond = year_ge;
            ecd_pkg::OP_MONTH: cond = month_ge;
            default:           cond = 1'b0;
        endcase
    end

    // Execute the control word
    always_comb
    begin
        acc_next    = acc_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (accept)
        begin
            acc_next = epoch_seconds;
        end
        else if (run)
        begin
            case (cw.op)
                ecd_pkg::OP_DAY_Q:
                begin
                    days_next = day_prod[ecd_pkg::DAY_SH +: ecd_pkg::DAYS_W];
                end
                ecd_pkg::OP_DAY_R:
                begin
                    acc_next = acc_reg - day_secs;
                end
                ecd_pkg::OP_HOUR_Q:
                begin
                    hour_next = hour_prod[ecd_pkg::HOUR_SH +: ecd_pkg::HOUR_W];
                end
                ecd_pkg::OP_HOUR_R:
                begin
                    acc_next = acc_reg - hour_secs;
                end
                ecd_pkg::OP_MIN_Q:
                begin
                    minute_next = min_prod[ecd_pkg::MIN_SH +: ecd_pkg::MIN_W];
                end
                ecd_pkg::OP_MIN_R:
                begin
                    second_next = sec_left[ecd_pkg::SEC_W-1:0];
                    year_next   = ecd_pkg::EPOCH_YEAR;
                    month_next  = ecd_pkg::MONTH_JAN;
                end
                ecd_pkg::OP_YEAR:
                begin
                    if (year_ge)
                    begin
                        days_next = days_reg - {{(ecd_pkg::DAYS_W-ecd_pkg::YLEN_W){1'b0}}, ylen};
                        year_next = year_reg + 1'b1;
                    end
                end
                ecd_pkg::OP_MONTH:
                begin
                    if (month_ge)
                    begin
                        days_next  = days_reg - {{(ecd_pkg::DAYS_W-ecd_pkg::DAY_W){1'b0}}, mlen};
                        month_next = month_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

    // Day of month counts from 1; remaining days stay below 31 here
    assign cal_year   = year_reg;
    assign cal_month  = month_reg;
    assign cal_day    = days_reg[ecd_pkg::DAY_W-1:0] + 1'b1;
    assign cal_hour   = hour_reg;
    assign cal_minute = minute_reg;
    assign cal_second = second_reg;

endmodule

`default_nettype wire
